@@ rtl/clipped_chroma_key_blitter_core_defines.svh @@
// ----------------------------------------------------------------------------
// Chroma key blitter assertion macros
// Shared assertion wrappers for the blitter core.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_CHROMA_KEY_BLITTER_CORE_DEFINES_SVH
`define CLIPPED_CHROMA_KEY_BLITTER_CORE_DEFINES_SVH

// clocked check, off while reset is asserted
`define CKB_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// implication checked every clock, off while reset is asserted
`define CKB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/ckb_pkg.sv @@
// ----------------------------------------------------------------------------
// Chroma key blitter package
// Register map, shared types and the per-channel blend function.
// ----------------------------------------------------------------------------
`default_nettype none

package ckb_pkg;

    localparam int REG_ADDR_W = 5;
    localparam int REG_DATA_W = 32;
    localparam int POS_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int COLOR_W    = 25;

    localparam logic [2:0] REG_DEST_X    = 3'd0;
    localparam logic [2:0] REG_DEST_Y    = 3'd1;
    localparam logic [2:0] REG_WIDTH     = 3'd2;
    localparam logic [2:0] REG_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_KEY       = 3'd4;
    localparam logic [2:0] REG_REPLACE   = 3'd5;
    localparam logic [2:0] REG_BLEND     = 3'd6;

    typedef struct packed {
        logic [SIZE_W-1:0]  dest_x;
        logic [SIZE_W-1:0]  dest_y;
        logic [SIZE_W-1:0]  region_width;
        logic [SIZE_W-1:0]  region_height;
        logic [COLOR_W-1:0] chroma_key;
        logic [COLOR_W-1:0] replace_color;
        logic               blend_enable;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             done;
    } raster_t;

    // floor((a*s + (255-a)*d) / 255); exact reciprocal form for 16-bit sums
    function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] s,
                                          input logic [7:0] d);
        logic [15:0] n;
        logic [16:0] t;
        n = 16'(a) * 16'(s) + 16'(8'd255 - a) * 16'(d);
        t = 17'(n) + 17'(n[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

@@ rtl/ckb_cfg.sv @@
// ----------------------------------------------------------------------------
// Chroma key blitter register file
// APB-style configuration registers with read back.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_cfg
    import ckb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [REG_ADDR_W-1:0] paddr,
    input  wire logic [REG_DATA_W-1:0] pwdata,
    output logic      [REG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_x        <= '0;
            cfg_reg.dest_y        <= '0;
            cfg_reg.region_width  <= SIZE_W'(1);
            cfg_reg.region_height <= SIZE_W'(1);
            cfg_reg.chroma_key    <= '1;
            cfg_reg.replace_color <= '1;
            cfg_reg.blend_enable  <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                REG_DEST_X:  cfg_reg.dest_x        <= pwdata[SIZE_W-1:0];
                REG_DEST_Y:  cfg_reg.dest_y        <= pwdata[SIZE_W-1:0];
                REG_WIDTH:   cfg_reg.region_width  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT:  cfg_reg.region_height <= pwdata[SIZE_W-1:0];
                REG_KEY:     cfg_reg.chroma_key    <= pwdata[COLOR_W-1:0];
                REG_REPLACE: cfg_reg.replace_color <= pwdata[COLOR_W-1:0];
                REG_BLEND:   cfg_reg.blend_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_DEST_X:  prdata = REG_DATA_W'(cfg_reg.dest_x);
            REG_DEST_Y:  prdata = REG_DATA_W'(cfg_reg.dest_y);
            REG_WIDTH:   prdata = REG_DATA_W'(cfg_reg.region_width);
            REG_HEIGHT:  prdata = REG_DATA_W'(cfg_reg.region_height);
            REG_KEY:     prdata = REG_DATA_W'(cfg_reg.chroma_key);
            REG_REPLACE: prdata = REG_DATA_W'(cfg_reg.replace_color);
            REG_BLEND:   prdata = REG_DATA_W'(cfg_reg.blend_enable);
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/ckb_raster.sv @@
// ----------------------------------------------------------------------------
// Chroma key blitter raster counter
// Column and row position of the current source word, advanced per accept.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_raster
    import ckb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic [SIZE_W-1:0] region_width,
    input  wire logic [SIZE_W-1:0] region_height,
    output raster_t                pos
);

    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(4096);

    logic [POS_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic              last_col, last_row;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        if (v == '0) return SIZE_W'(1);
        if (v > SIZE_MAX) return SIZE_MAX;
        return v;
    endfunction

    always_comb begin
        w_eff    = eff_size(region_width);
        h_eff    = eff_size(region_height);
        // a shrunk region can leave a counter past the end; treat it as last
        last_col = (SIZE_W'(col_reg) + SIZE_W'(1)) >= w_eff;
        last_row = (SIZE_W'(row_reg) + SIZE_W'(1)) >= h_eff;
        col_next = col_reg;
        row_next = row_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + POS_W'(1);
        end else begin
            col_next = col_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.col  = col_reg;
    assign pos.row  = row_reg;
    assign pos.done = last_col && last_row;

endmodule

`default_nettype wire

@@ rtl/clipped_chroma_key_blitter_core.sv @@
// An accepted word goes into the input register, then through the pixel logic into the
// result register on the m_ side; one word per cycle while m_tready does not stall.
// The result register frees up when m_tready is high, so s_tready stays high under flow.
// Reset (aresetn low, synchronous) empties both stages, zeroes the raster counters
// and loads register defaults: key and replace off, blend off, region 1x1 at origin.
`default_nettype none

`include "clipped_chroma_key_blitter_core_defines.svh"

// ----------------------------------------------------------------------------
// Clipped chroma key blitter core
// Places, clips, keys, recolors and blends a raster stream of source pixels.
// ----------------------------------------------------------------------------
module clipped_chroma_key_blitter_core
    import ckb_pkg::*;
#(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // src_blue, src_green, src_red, src_alpha, dst_blue, dst_green, dst_red
    input  wire logic [55:0]           s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // frame_x, frame_y, out_blue, out_green, out_red, out_alpha, 4 bits zero
    output logic      [55:0]           m_tdata,
    // write_enable
    output logic      [0:0]            m_tuser,
    output logic                       m_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [REG_ADDR_W-1:0] paddr,
    input  wire logic [REG_DATA_W-1:0] pwdata,
    output logic      [REG_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t     cfg;
    raster_t  pos;

    logic        s1_valid_reg;
    logic [55:0] s1_data_reg;
    raster_t     s1_pos_reg;

    logic        m_valid_reg;
    logic [55:0] m_data_reg, m_data_next;
    logic        m_we_reg, m_we_next;
    logic        m_last_reg;

    logic        out_ready, s_accept, s1_move;

    logic [7:0]  sb, sg, sr, sa, db, dg, dr;
    logic [7:0]  cb, cg, cr;
    logic [7:0]  ob, og, orr, oa;
    logic [13:0] fx, fy;
    logic        in_frame, keyed;

    assign out_ready = !m_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign s1_move   = s1_valid_reg && out_ready;

    ckb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ckb_raster u_raster (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (s_accept),
        .region_width  (cfg.region_width),
        .region_height (cfg.region_height),
        .pos           (pos)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_data_reg <= s_tdata;
            s1_pos_reg  <= pos;
        end
    end

    // pixel logic
    always_comb begin
        sb = s1_data_reg[7:0];
        sg = s1_data_reg[15:8];
        sr = s1_data_reg[23:16];
        sa = s1_data_reg[31:24];
        db = s1_data_reg[39:32];
        dg = s1_data_reg[47:40];
        dr = s1_data_reg[55:48];

        fx = {cfg.dest_x[SIZE_W-1], cfg.dest_x} + {2'b00, s1_pos_reg.col};
        fy = {cfg.dest_y[SIZE_W-1], cfg.dest_y} + {2'b00, s1_pos_reg.row};
        in_frame = !fx[13] && (fx[12:0] < 13'(FRAME_WIDTH)) &&
                   !fy[13] && (fy[12:0] < 13'(FRAME_HEIGHT));

        // sign bit of the key register disables keying
        keyed = !cfg.chroma_key[24] && (cfg.chroma_key[23:0] == {sr, sg, sb});
        m_we_next = in_frame && !keyed;

        if (!cfg.replace_color[24]) begin
            cr = cfg.replace_color[23:16];
            cg = cfg.replace_color[15:8];
            cb = cfg.replace_color[7:0];
        end else begin
            cr = sr;
            cg = sg;
            cb = sb;
        end

        if (cfg.blend_enable) begin
            ob  = blend8(sa, cb, db);
            og  = blend8(sa, cg, dg);
            orr = blend8(sa, cr, dr);
            oa  = 8'd255;
        end else begin
            ob  = cb;
            og  = cg;
            orr = cr;
            oa  = sa;
        end

        if (m_we_next) begin
            m_data_next = {4'b0000, oa, orr, og, ob, fy[9:0], fx[9:0]};
        end else begin
            m_data_next = '0;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_data_reg <= m_data_next;
            m_we_reg   <= m_we_next;
            m_last_reg <= s1_pos_reg.done;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_we_reg;
    assign m_tlast    = m_last_reg;

    // skipped pixels carry an all-zero word
    `CKB_ASSERT_IMP(a_skip_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "skipped word not zero")
    // blended writes are opaque
    `CKB_ASSERT_IMP(a_blend_alpha, m_tvalid && m_tuser[0] && cfg.blend_enable, m_tdata[51:44] == 8'd255, "blend alpha not opaque")
    // a held input word stays put until the result stage frees
    `CKB_ASSERT_CLK(a_s1_hold, s1_valid_reg && !out_ready |=> s1_valid_reg && $stable(s1_data_reg), "input stage lost a word")
    // end of region restarts the raster at the origin
    `CKB_ASSERT_CLK(a_raster_wrap, s_accept && pos.done |=> pos.col == '0 && pos.row == '0, "raster did not wrap")

endmodule

`default_nettype wire
